// ===== rtl/pec_pkg.sv =====
// shared types and constants for the postfix expression evaluator
package pec_pkg;

  localparam int WORD_W = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;

  localparam logic [WORD_W-1:0] EMPTY_VAL = '1;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_UP,
    CELL_LOAD_DN1,
    CELL_LOAD_DN2
  } cell_op_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/pec_cell.sv =====
// one stack cell: holds an entry and moves it to or from its neighbours
module pec_cell (
  input  logic                      clk,
  input  pec_pkg::cell_op_t         op,
  input  logic [pec_pkg::WORD_W-1:0] from_up,
  input  logic [pec_pkg::WORD_W-1:0] from_dn1,
  input  logic [pec_pkg::WORD_W-1:0] from_dn2,
  output logic [pec_pkg::WORD_W-1:0] val
);
  import pec_pkg::*;

  logic [WORD_W-1:0] val_r;
  logic [WORD_W-1:0] val_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:     val_nxt = val_r;
      CELL_LOAD_UP:  val_nxt = from_up;
      CELL_LOAD_DN1: val_nxt = from_dn1;
      CELL_LOAD_DN2: val_nxt = from_dn2;
      default:       val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== rtl/pec_div.sv =====
// iterative radix-2 signed divider, truncating toward zero
module pec_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pec_pkg::div_req_t          req,
  output logic                       done,
  output logic [pec_pkg::WORD_W-1:0] quotient
);
  import pec_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] den_r;
  logic              neg_r;

  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] abs_a;
  logic [WORD_W-1:0] abs_b;

  assign abs_a = req.dividend[WORD_W-1] ? -req.dividend : req.dividend;
  assign abs_b = req.divisor[WORD_W-1]  ? -req.divisor  : req.divisor;
  assign trial = {rem_r, quo_r[WORD_W-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= abs_a;
        den_r  <= abs_b;
        neg_r  <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
      end else if (busy_r) begin
        if (!trial[WORD_W]) begin
          rem_r <= trial[WORD_W-1:0];
        end else begin
          rem_r <= {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        end
        quo_r <= {quo_r[WORD_W-2:0], ~trial[WORD_W]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// top level of the postfix expression evaluator
// Evaluates a postfix expression fed one ASCII byte per input word on
// in_ch, with in_last marking the final byte. Digits push 0..9; + - * /
// pop two operands and push the result; any other byte pops two and
// pushes nothing. An empty stack pops as -1 and flags underflow.
// One result word (out_value, out_status) follows each expression.
// Every byte is handled in S_IDLE but / with a non-zero divisor, which
// waits in S_DIV for the 32 steps of the radix-2 divider and then writes
// the quotient back; a byte with in_last goes through S_FIN to load
// the output register. in_ready is high whenever no byte is in work. The
// stack is a chain of STACK_DEPTH cells that shift by at most two places
// per byte. Reset clears the entry count, the status and out_valid, not
// the output value and status; the stack cells need no reset. When the
// receiver stalls, the result stays in the output register and bytes
// keep being taken; only a further last byte waits for it to drain.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_ch,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_value,
  output logic [1:0]                 out_status
);
  import pec_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  err_t              err_r, err_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic [WORD_W-1:0] cell_val [STACK_DEPTH];
  cell_op_t          cell_op  [STACK_DEPTH];
  cell_op_t          chain_op;
  cell_op_t          top_op;
  logic [WORD_W-1:0] push_val;

  div_req_t          div_req;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  logic              accept;
  logic              is_digit;
  logic              full;
  logic              under;
  logic [WORD_W-1:0] rhs, lhs;
  logic [CW-1:0]     cnt_pop;
  err_t              new_err;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign under    = (count_r < CW'(2));
  assign rhs      = (count_r >= CW'(1)) ? cell_val[0] : EMPTY_VAL;
  assign lhs      = (count_r >= CW'(2)) ? cell_val[1] : EMPTY_VAL;
  assign cnt_pop  = under ? '0 : count_r - CW'(2);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    chain_op       = CELL_HOLD;
    top_op         = CELL_HOLD;
    push_val       = '0;
    new_err        = ERR_NONE;
    div_req.start    = 1'b0;
    div_req.dividend = lhs;
    div_req.divisor  = rhs;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt  = in_last;
          state_nxt = in_last ? S_FIN : S_IDLE;
          if (is_digit) begin
            if (full) begin
              new_err = ERR_OVER;
            end else begin
              push_val  = WORD_W'(in_ch - CH_ZERO);
              chain_op  = CELL_LOAD_UP;
              top_op    = CELL_LOAD_UP;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            if (under) begin
              new_err = ERR_UNDER;
            end
            if (in_ch == CH_PLUS || in_ch == CH_MINUS || in_ch == CH_MUL ||
                (in_ch == CH_DIV && rhs == '0)) begin
              chain_op  = CELL_LOAD_DN1;
              top_op    = CELL_LOAD_UP;
              count_nxt = cnt_pop + CW'(1);
              if (in_ch == CH_PLUS) begin
                push_val = lhs + rhs;
              end else if (in_ch == CH_MINUS) begin
                push_val = lhs - rhs;
              end else if (in_ch == CH_MUL) begin
                push_val = WORD_W'(lhs * rhs);
              end else begin
                push_val = '0;
                if (!under) begin
                  new_err = ERR_DIVZ;
                end
              end
            end else begin
              chain_op  = CELL_LOAD_DN2;
              top_op    = CELL_LOAD_DN2;
              count_nxt = cnt_pop;
              if (in_ch == CH_DIV) begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
          end
          if (err_r == ERR_NONE) begin
            err_nxt = new_err;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          push_val  = div_q;
          chain_op  = CELL_LOAD_UP;
          top_op    = CELL_LOAD_UP;
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (count_r == '0) ? EMPTY_VAL : cell_val[0];
          if (err_r != ERR_NONE) begin
            out_status_nxt = err_r;
          end else if (count_r == '0) begin
            out_status_nxt = ERR_UNDER;
          end else begin
            out_status_nxt = ERR_NONE;
          end
          count_nxt = '0;
          err_nxt   = ERR_NONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ERR_NONE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // stack cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_w, dn1_w, dn2_w;

    if (i == 0) begin : g_top
      assign up_w        = push_val;
      assign cell_op[i]  = top_op;
    end else begin : g_mid
      assign up_w        = cell_val[i-1];
      assign cell_op[i]  = chain_op;
    end

    if (i + 1 < STACK_DEPTH) begin : g_dn1
      assign dn1_w = cell_val[i+1];
    end else begin : g_dn1_end
      assign dn1_w = '0;
    end

    if (i + 2 < STACK_DEPTH) begin : g_dn2
      assign dn2_w = cell_val[i+2];
    end else begin : g_dn2_end
      assign dn2_w = '0;
    end

    pec_cell u_cell (
      .clk      (clk),
      .op       (cell_op[i]),
      .from_up  (up_w),
      .from_dn1 (dn1_w),
      .from_dn2 (dn2_w),
      .val      (cell_val[i])
    );
  end

  pec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

endmodule

// ===== test/pec_result_monitor.sv =====
// result monitor: evaluates each accepted byte and checks the result words of the evaluator
`timescale 1ns / 1ps
module pec_result_monitor #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_value,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 results_outstanding
);
  import pec_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    err_t              status;
  } expr_result_t;

  logic [WORD_W-1:0] operand_words [STACK_DEPTH];
  int unsigned       operand_count;
  err_t              first_fault;
  expr_result_t      evaluated_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void note_fault(input err_t code);
    if (first_fault == ERR_NONE) begin
      first_fault = code;
    end
  endfunction

  function automatic void push_operand(input logic [WORD_W-1:0] v);
    if (operand_count >= STACK_DEPTH) begin
      note_fault(ERR_OVER);
    end else begin
      operand_words[operand_count] = v;
      operand_count++;
    end
  endfunction

  function automatic logic [WORD_W-1:0] pop_operand();
    if (operand_count == 0) begin
      note_fault(ERR_UNDER);
      return EMPTY_VAL;
    end
    operand_count--;
    return operand_words[operand_count];
  endfunction

  function automatic logic [WORD_W-1:0] trunc_quotient(input logic [WORD_W-1:0] lhs,
                                                       input logic [WORD_W-1:0] rhs);
    longint num, den, quo;
    num = $signed(lhs);
    den = $signed(rhs);
    if (den == 0) begin
      note_fault(ERR_DIVZ);
      return '0;
    end
    quo = num / den;
    return quo[WORD_W-1:0];
  endfunction

  task automatic evaluate_byte(input logic [7:0] ch, input logic last);
    logic [WORD_W-1:0] rhs, lhs, top;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      push_operand(WORD_W'(ch - CH_ZERO));
    end else begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (ch)
        CH_PLUS:  push_operand(lhs + rhs);
        CH_MINUS: push_operand(lhs - rhs);
        CH_MUL:   push_operand(lhs * rhs);
        CH_DIV:   push_operand(trunc_quotient(lhs, rhs));
        default:  ;
      endcase
    end
    if (last) begin
      if (operand_count == 0) begin
        note_fault(ERR_UNDER);
        top = EMPTY_VAL;
      end else begin
        top = operand_words[operand_count - 1];
      end
      evaluated_results.push_back('{top, first_fault});
      operand_count = 0;
      first_fault   = ERR_NONE;
    end
  endtask

  always @(posedge clk) begin
    expr_result_t got;
    if (!rst_n) begin
      operand_count = 0;
      first_fault   = ERR_NONE;
      fail_count    = 0;
      evaluated_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (evaluated_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word: value %0d status %0d",
                                    out_value, out_status));
        end else begin
          got = evaluated_results.pop_front();
          if (out_value !== got.value) begin
            report_mismatch($sformatf("value %0d, predicted %0d",
                                      out_value, $signed(got.value)));
          end
          if (out_status !== got.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d (%s)",
                                      out_status, got.status, got.status.name()));
          end
        end
      end
      if (in_valid && in_ready) begin
        evaluate_byte(in_ch, in_last);
      end
    end
    results_outstanding <= evaluated_results.size();
  end

endmodule

// ===== test/tb_postfix_expression_evaluator.sv =====
// testbench top: feeds postfix expressions to the evaluator and gives the verdict
`timescale 1ns / 1ps
module tb_postfix_expression_evaluator;
  import pec_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int ITEM_TARGET = 750;
  localparam logic [7:0] OPERATORS [4] = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         in_ch     = '0;
  logic               in_last   = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]         out_status;

  int         fail_count;
  int         results_outstanding;
  int         bytes_sent = 0;
  int         ready_hold = 0;
  bit         steady     = 1'b0;
  logic [7:0] expr_bytes [$];

  always #2 clk = ~clk;

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_status(out_status)
  );

  pec_result_monitor #(
    .STACK_DEPTH(STACK_DEPTH)
  ) result_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_value          (out_value),
    .out_status         (out_status),
    .fail_count         (fail_count),
    .results_outstanding(results_outstanding)
  );

  // receiver: after a result word, stall for a random hold unless steady is set
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        stall = steady ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
          out_ready  <= 1'b0;
          ready_hold <= stall;
        end
      end
    end else begin
      if (ready_hold <= 1) begin
        out_ready <= 1'b1;
      end
      ready_hold <= ready_hold - 1;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= ch;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_expr();
    steady = ($urandom_range(0, 4) == 0);
    foreach (expr_bytes[i]) begin
      send_byte(expr_bytes[i], i == expr_bytes.size() - 1);
    end
    expr_bytes.delete();
  endtask

  task automatic add_digit(input int n);
    expr_bytes.push_back(CH_ZERO + 8'(n));
  endtask

  task automatic build_wellformed(input int operand_total, input int depth_cap);
    int depth, digits_left, ops_left;
    depth       = 0;
    digits_left = operand_total;
    ops_left    = operand_total - 1;
    while (digits_left + ops_left > 0) begin
      if (depth >= 2 && ops_left > 0 &&
          (digits_left == 0 || depth >= depth_cap || $urandom_range(0, 1) == 1)) begin
        expr_bytes.push_back(OPERATORS[$urandom_range(0, 3)]);
        depth--;
        ops_left--;
      end else begin
        add_digit($urandom_range(0, 9));
        depth++;
        digits_left--;
      end
    end
  endtask

  task automatic build_random_expr(input int kind);
    int n, pos;
    if (kind < 55) begin
      build_wellformed($urandom_range(1, 7), $urandom_range(2, 8));
    end else if (kind < 65) begin
      // deep push of 14 to 19 digits, overflowing only when it exceeds the stack depth
      n = $urandom_range(14, 19);
      repeat (n) add_digit($urandom_range(0, 9));
      repeat (n - 1) expr_bytes.push_back(OPERATORS[$urandom_range(0, 3)]);
    end else if (kind < 70) begin
      // 8^10 * 2 wraps to the most negative word, then divided
      add_digit(8);
      repeat (9) begin
        add_digit(8);
        expr_bytes.push_back(CH_MUL);
      end
      add_digit(2);
      expr_bytes.push_back(CH_MUL);
      if ($urandom_range(0, 3) != 0) begin
        add_digit(0);
        add_digit(1);
        expr_bytes.push_back(CH_MINUS);
      end else begin
        add_digit($urandom_range(0, 9));
      end
      expr_bytes.push_back(CH_DIV);
    end else if (kind < 85) begin
      build_wellformed($urandom_range(1, 6), $urandom_range(2, 6));
      case ($urandom_range(0, 2))
        0: begin
          pos = $urandom_range(0, expr_bytes.size() - 1);
          expr_bytes[pos] = 8'($urandom_range(0, 255));
        end
        1: expr_bytes.push_front(OPERATORS[$urandom_range(0, 3)]);
        default: begin
          if (expr_bytes.size() > 1) begin
            void'(expr_bytes.pop_back());
          end
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) expr_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int expr_idx;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_digit(3); add_digit(4); expr_bytes.push_back(CH_PLUS); send_expr();
    add_digit(9); add_digit(5); expr_bytes.push_back(CH_MINUS); send_expr();
    add_digit(7); add_digit(2); expr_bytes.push_back(CH_MUL); send_expr();
    // negative quotient truncates toward zero
    add_digit(0); add_digit(7); expr_bytes.push_back(CH_MINUS);
    add_digit(2); expr_bytes.push_back(CH_DIV); send_expr();
    add_digit(7); add_digit(0); expr_bytes.push_back(CH_DIV); send_expr();
    expr_bytes.push_back(CH_PLUS); send_expr();
    // non-operator bytes pop and push nothing, leaving the stack empty
    add_digit(1); add_digit(2); expr_bytes.push_back(8'h00); send_expr();
    add_digit(5); expr_bytes.push_back(8'hff); send_expr();
    add_digit(9); send_expr();

    expr_idx = 0;
    while (bytes_sent < ITEM_TARGET) begin
      build_random_expr(expr_idx == 0 ? 60 : expr_idx == 1 ? 67 : $urandom_range(0, 99));
      send_expr();
      expr_idx++;
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS postfix_expression_evaluator");
    end else begin
      $display("FAIL postfix_expression_evaluator");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL postfix_expression_evaluator");
    $finish;
  end

endmodule
